/* rtl/rgb_to_hsv_converter_unit_assert.svh */
// Assertion macros for the RGB to HSV converter.
`ifndef RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RHC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_to_hsv: implication check failed");

// Implication after a fixed number of cycles, disabled in reset.
`define RHC_ASSERT_DLY(name, ante, dly, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("rgb_to_hsv: delayed check failed");

`endif

/* rtl/rhc_pkg.sv */
// Shared constants and types for the RGB to HSV converter.
`default_nettype none
package rhc_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int HUE_BITS         = 15;
  localparam int HUE_SCALE_BITS   = 12;  // quotient of the hue division is at most 3840
  localparam int DIV_STEPS_DEF    = 12;

  localparam logic [HUE_BITS-1:0] HUE_SECTOR = 15'd3840;
  localparam logic [HUE_BITS-1:0] HUE_FULL   = 15'd23040;

  // Hue sector codes, red wins ties, then green.
  localparam logic [1:0] SECT_RED   = 2'd0;
  localparam logic [1:0] SECT_GREEN = 2'd1;
  localparam logic [1:0] SECT_BLUE  = 2'd2;

  typedef struct packed {
    logic [1:0] sector;
    logic       neg;    // hue offset is negative
    logic       black;  // max channel is zero
    logic       grey;   // max equals min
  } hue_ctl_t;

  // Base hue of a sector in 1/64 degree.
  function automatic logic [HUE_BITS-1:0] sector_base(input logic [1:0] sector);
    logic [HUE_BITS-1:0] base;
    base = '0;
    unique case (sector)
      SECT_RED:   base = '0;
      SECT_GREEN: base = HUE_SECTOR << 1;
      SECT_BLUE:  base = HUE_SECTOR << 2;
      default:    base = '0;
    endcase
    return base;
  endfunction

endpackage
`default_nettype wire

/* rtl/rhc_prep.sv */
// Front stages: max/min, sector and diff, then the constant scalings.
`default_nettype none
module rhc_prep
  import rhc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_vld,
  input  wire logic [CHANNEL_BITS-1:0]                red,
  input  wire logic [CHANNEL_BITS-1:0]                green,
  input  wire logic [CHANNEL_BITS-1:0]                blue,
  output logic                                        out_vld,
  output logic [2*CHANNEL_BITS-1:0]                   num_sat,
  output logic [CHANNEL_BITS+HUE_SCALE_BITS-1:0]      num_hue,
  output logic [CHANNEL_BITS-1:0]                     hi,
  output logic [CHANNEL_BITS-1:0]                     delta,
  output hue_ctl_t                                    ctl
);

  localparam int W  = CHANNEL_BITS;
  localparam int HW = CHANNEL_BITS + HUE_SCALE_BITS;

  logic [W-1:0] max_c, min_c;
  logic [W:0]   diff_c;
  logic [1:0]   sect_c;
  hue_ctl_t     ctl_c;

  logic           vld1_r, vld2_r;
  logic [W-1:0]   hi1_r, delta1_r, absdiff1_r;
  hue_ctl_t       ctl1_r, ctl2_r;
  logic [W-1:0]   hi2_r, delta2_r;
  logic [2*W-1:0] num_sat_r;
  logic [HW-1:0]  num_hue_r;

  always_comb begin
    max_c = red;
    min_c = red;
    if (green > max_c) max_c = green;
    if (blue > max_c)  max_c = blue;
    if (green < min_c) min_c = green;
    if (blue < min_c)  min_c = blue;
    if (red == max_c) begin
      sect_c = SECT_RED;
      diff_c = {1'b0, green} - {1'b0, blue};
    end else if (green == max_c) begin
      sect_c = SECT_GREEN;
      diff_c = {1'b0, blue} - {1'b0, red};
    end else begin
      sect_c = SECT_BLUE;
      diff_c = {1'b0, red} - {1'b0, green};
    end
    ctl_c.sector = sect_c;
    ctl_c.neg    = diff_c[W];
    ctl_c.black  = (max_c == '0);
    ctl_c.grey   = (max_c == min_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    hi1_r      <= max_c;
    delta1_r   <= max_c - min_c;
    absdiff1_r <= diff_c[W] ? W'(-diff_c) : diff_c[W-1:0];
    ctl1_r     <= ctl_c;
    // all-ones * delta and 3840 * |diff| as shift-subtracts
    num_sat_r  <= {delta1_r, {W{1'b0}}} - {{W{1'b0}}, delta1_r};
    num_hue_r  <= {absdiff1_r, {HUE_SCALE_BITS{1'b0}}}
                  - {4'b0, absdiff1_r, {(HUE_SCALE_BITS-4){1'b0}}};
    hi2_r      <= hi1_r;
    delta2_r   <= delta1_r;
    ctl2_r     <= ctl1_r;
  end

  assign out_vld = vld2_r;
  assign num_sat = num_sat_r;
  assign num_hue = num_hue_r;
  assign hi      = hi2_r;
  assign delta   = delta2_r;
  assign ctl     = ctl2_r;

endmodule
`default_nettype wire

/* rtl/rhc_div_pipe.sv */
// Two-lane pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module rhc_div_pipe
  import rhc_pkg::*;
#(
  parameter int DEN_W  = CHANNEL_BITS_DEF,
  parameter int STEPS  = DIV_STEPS_DEF,
  parameter int SIDE_W = CHANNEL_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_vld,
  input  wire logic [DEN_W+STEPS-1:0] num_a,
  input  wire logic [DEN_W-1:0]       den_a,
  input  wire logic [DEN_W+STEPS-1:0] num_b,
  input  wire logic [DEN_W-1:0]       den_b,
  input  wire logic [SIDE_W-1:0]      side_in,
  output logic                        out_vld,
  output logic [STEPS-1:0]            quo_a,
  output logic [STEPS-1:0]            quo_b,
  output logic [SIDE_W-1:0]           side_out
);

  localparam int RW = DEN_W + STEPS;

  logic              vld_r   [STEPS];
  logic [RW-1:0]     rem_a_r [STEPS];
  logic [RW-1:0]     rem_b_r [STEPS];
  logic [DEN_W-1:0]  den_a_r [STEPS];
  logic [DEN_W-1:0]  den_b_r [STEPS];
  logic [STEPS-1:0]  q_a_r   [STEPS];
  logic [STEPS-1:0]  q_b_r   [STEPS];
  logic [SIDE_W-1:0] side_r  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    logic              src_vld;
    logic [RW-1:0]     src_rem_a, src_rem_b;
    logic [DEN_W-1:0]  src_den_a, src_den_b;
    logic [STEPS-1:0]  src_q_a, src_q_b;
    logic [SIDE_W-1:0] src_side;
    logic [RW:0]       trial_a, trial_b;

    if (k == 0) begin : g_first
      assign src_vld   = in_vld;
      assign src_rem_a = num_a;
      assign src_rem_b = num_b;
      assign src_den_a = den_a;
      assign src_den_b = den_b;
      assign src_q_a   = '0;
      assign src_q_b   = '0;
      assign src_side  = side_in;
    end else begin : g_next
      assign src_vld   = vld_r[k-1];
      assign src_rem_a = rem_a_r[k-1];
      assign src_rem_b = rem_b_r[k-1];
      assign src_den_a = den_a_r[k-1];
      assign src_den_b = den_b_r[k-1];
      assign src_q_a   = q_a_r[k-1];
      assign src_q_b   = q_b_r[k-1];
      assign src_side  = side_r[k-1];
    end

    // subtract the divisor aligned to quotient bit STEPS-1-k
    assign trial_a = {1'b0, src_rem_a} - ({1'b0, RW'(src_den_a)} << (STEPS - 1 - k));
    assign trial_b = {1'b0, src_rem_b} - ({1'b0, RW'(src_den_b)} << (STEPS - 1 - k));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem_a_r[k] <= trial_a[RW] ? src_rem_a : trial_a[RW-1:0];
      rem_b_r[k] <= trial_b[RW] ? src_rem_b : trial_b[RW-1:0];
      q_a_r[k]   <= {src_q_a[STEPS-2:0], ~trial_a[RW]};
      q_b_r[k]   <= {src_q_b[STEPS-2:0], ~trial_b[RW]};
      den_a_r[k] <= src_den_a;
      den_b_r[k] <= src_den_b;
      side_r[k]  <= src_side;
    end
  end

  assign out_vld  = vld_r[STEPS-1];
  assign quo_a    = q_a_r[STEPS-1];
  assign quo_b    = q_b_r[STEPS-1];
  assign side_out = side_r[STEPS-1];

endmodule
`default_nettype wire

/* rtl/rgb_to_hsv_converter_unit.sv */
// Path to out_valid: input regs, prep stages, divider, output reg; STEPS = max(CHANNEL_BITS, 12).
// Throughput: one pixel per clock; busy drops once out of reset and then stays low.
// The depth is set by the divider pipeline, one quotient bit per stage.
// Results come out as one-cycle strobes; the receiver cannot stall.
// Synchronous active-low reset clears all valid bits and holds busy high.
// Top level of the pipelined RGB to HSV converter.
`default_nettype none
`include "rgb_to_hsv_converter_unit_assert.svh"
module rgb_to_hsv_converter_unit
  import rhc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [CHANNEL_BITS-1:0] in_red,
  input  wire logic [CHANNEL_BITS-1:0] in_green,
  input  wire logic [CHANNEL_BITS-1:0] in_blue,
  output logic                         out_valid,
  output logic [HUE_BITS-1:0]          out_hue,
  output logic [CHANNEL_BITS-1:0]      out_saturation,
  output logic [CHANNEL_BITS-1:0]      out_brightness,
  output logic                         out_hue_undefined
);

  localparam int W       = CHANNEL_BITS;
  localparam int STEPS   = (W > HUE_SCALE_BITS) ? W : HUE_SCALE_BITS;
  localparam int RW      = W + STEPS;
  localparam int SIDE_W  = W + $bits(hue_ctl_t);
  localparam int LATENCY = STEPS + 4;

  logic         busy_r;
  logic         in_vld_r;
  logic [W-1:0] red_r, green_r, blue_r;

  logic                      prep_vld;
  logic [2*W-1:0]            num_sat;
  logic [W+HUE_SCALE_BITS-1:0] num_hue;
  logic [W-1:0]              prep_hi, prep_delta;
  hue_ctl_t                  prep_ctl;

  logic               div_vld;
  logic [STEPS-1:0]   quo_sat, quo_hue;
  logic [SIDE_W-1:0]  div_side;
  logic [W-1:0]       div_hi;
  hue_ctl_t           div_ctl;

  logic [HUE_SCALE_BITS-1:0] hue_q;
  logic [HUE_BITS:0]         hue_wide;
  logic [HUE_BITS-1:0]       hue_nxt;
  logic [W-1:0]              sat_nxt;

  logic                out_vld_r;
  logic [HUE_BITS-1:0] hue_r;
  logic [W-1:0]        sat_r, bright_r;
  logic                undef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      busy_r    <= 1'b0;
      in_vld_r  <= start && !busy_r;
      out_vld_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= in_red;
    green_r <= in_green;
    blue_r  <= in_blue;
  end

  rhc_prep #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld_r),
    .red     (red_r),
    .green   (green_r),
    .blue    (blue_r),
    .out_vld (prep_vld),
    .num_sat (num_sat),
    .num_hue (num_hue),
    .hi      (prep_hi),
    .delta   (prep_delta),
    .ctl     (prep_ctl)
  );

  // lane a: saturation = full*delta/max, lane b: hue offset = 3840*|diff|/delta
  rhc_div_pipe #(
    .DEN_W  (W),
    .STEPS  (STEPS),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (prep_vld),
    .num_a    (RW'(num_sat)),
    .den_a    (prep_hi),
    .num_b    (RW'(num_hue)),
    .den_b    (prep_delta),
    .side_in  ({prep_hi, prep_ctl}),
    .out_vld  (div_vld),
    .quo_a    (quo_sat),
    .quo_b    (quo_hue),
    .side_out (div_side)
  );

  assign div_hi  = div_side[SIDE_W-1 -: W];
  assign div_ctl = div_side[$bits(hue_ctl_t)-1:0];
  assign hue_q   = quo_hue[HUE_SCALE_BITS-1:0];

  always_comb begin
    if (div_ctl.neg) begin
      hue_wide = {1'b0, sector_base(div_ctl.sector)} - (HUE_BITS+1)'(hue_q);
    end else begin
      hue_wide = {1'b0, sector_base(div_ctl.sector)} + (HUE_BITS+1)'(hue_q);
    end
    // only the red sector can wrap below zero
    if (hue_wide[HUE_BITS]) begin
      hue_wide = hue_wide + {1'b0, HUE_FULL};
    end
    hue_nxt = hue_wide[HUE_BITS-1:0];
    sat_nxt = quo_sat[W-1:0];
    if (div_ctl.black || div_ctl.grey) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    hue_r    <= hue_nxt;
    sat_r    <= sat_nxt;
    bright_r <= div_hi;
    undef_r  <= div_ctl.black;
  end

  assign busy              = busy_r;
  assign out_valid         = out_vld_r;
  assign out_hue           = hue_r;
  assign out_saturation    = sat_r;
  assign out_brightness    = bright_r;
  assign out_hue_undefined = undef_r;

  `RHC_ASSERT_DLY(a_latency, start && !busy, LATENCY, out_valid)
  `RHC_ASSERT_IMP(a_black_zero, out_valid && out_hue_undefined, out_brightness == '0 && out_hue == '0 && out_saturation == '0)
  `RHC_ASSERT_IMP(a_hue_range, out_valid, out_hue < HUE_FULL)
  `RHC_ASSERT_IMP(a_grey_hue, out_valid && out_saturation == '0, out_hue == '0)

endmodule
`default_nettype wire
